@@ src/pbwmm_pkg.sv @@
// Package for the per-beam window min/max unit.
// Holds the shared sample type, the accumulator control struct and the sequencer states.
// No dependencies.
package pbwmm_pkg;

  // Default sizes of the scan ring.
  localparam int WINDOW_DEF = 400;
  localparam int BEAMS_DEF  = 721;

  // Width and reset value of the window length register.
  localparam int             WL_W     = 9;
  localparam logic [WL_W-1:0] WL_RESET = 9'd400;

  // Field widths of the input and result transactions.
  localparam int BEAM_W = 10;
  localparam int VAL_W  = 16;

  // Lane order inside a sample word.
  localparam int LANE_DIST   = 0;
  localparam int LANE_INT    = 1;
  localparam int LANE_INTRIN = 2;
  localparam int LANES       = 3;

  // One stored beam: distance, intensity and intrinsic intensity.
  typedef logic [LANES-1:0][VAL_W-1:0] sample_t;

  // Control from the sequencer to the extreme accumulator.
  typedef struct packed {
    logic init;    // load current values as both extremes
    logic update;  // fold the read-back sample into the extremes
  } acc_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } seq_state_e;

endpackage

@@ src/pbwmm_sample_ram.sv @@
// Sample store of the per-beam window min/max unit.
// Simple dual-port synchronous RAM with registered read data. Uses pbwmm_pkg.
module pbwmm_sample_ram
  import pbwmm_pkg::*;
#(
  parameter int DEPTH  = WINDOW_DEF * BEAMS_DEF,
  parameter int ADDR_W = $clog2(WINDOW_DEF * BEAMS_DEF)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  sample_t           wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output sample_t           rdata_o
);

  sample_t mem_q [DEPTH];
  sample_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pbwmm_extreme_acc.sv @@
// Running maximum and minimum of the three beam quantities.
// Driven by the sequencer through acc_ctrl_t. Uses pbwmm_pkg.
module pbwmm_extreme_acc
  import pbwmm_pkg::*;
(
  input  logic      clk_i,
  input  acc_ctrl_t ctrl_i,
  input  sample_t   cur_i,
  input  sample_t   rd_i,
  output sample_t   hi_o,
  output sample_t   lo_o
);

  sample_t hi_q, hi_d;
  sample_t lo_q, lo_d;

  // Each lane compares independently against the read-back sample.
  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (ctrl_i.init) begin
      hi_d = cur_i;
      lo_d = cur_i;
    end else if (ctrl_i.update) begin
      for (int q = 0; q < LANES; q++) begin
        if (rd_i[q] > hi_q[q]) begin
          hi_d[q] = rd_i[q];
        end
        if (rd_i[q] < lo_q[q]) begin
          lo_d[q] = rd_i[q];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign hi_o = hi_q;
  assign lo_o = lo_q;

endmodule

@@ src/per_beam_window_min_max_unit.sv @@
// Top level of the per-beam window min/max unit.
// Instantiates pbwmm_sample_ram and pbwmm_extreme_acc; uses pbwmm_pkg.

// Each input transaction stores its beam, if in range, in the current ring slot and
// returns one result: the maximum and minimum of distance, intensity and intrinsic
// intensity at that beam position over the current scan and the window_length-1 scans
// before it; until that many older scans are held, or off the scan, of the current
// values alone. When the window is full and spans more than one scan, the unit walks
// over the older scans through the single read port of the sample RAM, one entry per
// cycle, then drains the last read and loads the result; else it loads it directly.
// The next item is accepted in the cycle after the result is loaded. A result waiting
// in the output register stalls completion of the following item only. The store needs
// no clearing pass after reset; entries are defined once written. window_length is
// clamped to 1..WINDOW and should be written only while the unit is idle.
module per_beam_window_min_max_unit
  import pbwmm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int BEAMS  = BEAMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration
  input  logic              cfg_we_i,
  input  logic [WL_W-1:0]   cfg_wdata_i,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BEAM_W-1:0] beam_index_i,
  input  logic [VAL_W-1:0]  distance_i,
  input  logic [VAL_W-1:0]  intensity_i,
  input  logic [VAL_W-1:0]  intrinsic_intensity_i,
  input  logic              scan_end_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  max_distance_o,
  output logic [VAL_W-1:0]  min_distance_o,
  output logic [VAL_W-1:0]  max_intensity_o,
  output logic [VAL_W-1:0]  min_intensity_o,
  output logic [VAL_W-1:0]  max_intrinsic_o,
  output logic [VAL_W-1:0]  min_intrinsic_o,
  output logic              window_full_o,
  output logic              scan_done_o
);

  localparam int TOTAL  = WINDOW * BEAMS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int LEN_W  = (CNT_W > WL_W) ? CNT_W : WL_W;

  localparam logic [ADDR_W-1:0] BEAMS_A = ADDR_W'(BEAMS);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(TOTAL - BEAMS);
  localparam logic [CNT_W-1:0]  WIN_C   = CNT_W'(WINDOW);
  localparam logic [LEN_W-1:0]  WIN_L   = LEN_W'(WINDOW);

  // Configuration register.
  logic [WL_W-1:0] wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (cfg_we_i) begin
      wl_q <= cfg_wdata_i;
    end
  end

  // Window length clamped to 1..WINDOW.
  logic [LEN_W-1:0] wl_ext;
  logic [CNT_W-1:0] len_c;

  always_comb begin
    wl_ext = LEN_W'(wl_q);
    if (wl_ext == '0) begin
      len_c = CNT_W'(1);
    end else if (wl_ext > WIN_L) begin
      len_c = WIN_C;
    end else begin
      len_c = CNT_W'(wl_ext);
    end
  end

  // Ring state: base address of the current slot and number of completed scans.
  logic [ADDR_W-1:0] base_q, base_d;
  logic [CNT_W-1:0]  held_q, held_d;

  // Sequencer registers.
  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] rd_addr_q, rd_addr_d;
  logic              rd_vld_q, rd_vld_d;
  logic              full_q, full_d;
  logic              end_q, end_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  sample_t out_hi_q, out_lo_q;
  logic    out_full_q, out_end_q;
  logic    out_load;

  // Memory and accumulator hookup.
  logic              accept;
  logic              beam_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] step_addr;
  logic              mem_we, mem_re;
  sample_t           cur_s, rd_s, hi_s, lo_s;
  acc_ctrl_t         acc_ctrl;
  logic              is_full;

  assign cur_s[LANE_DIST]   = distance_i;
  assign cur_s[LANE_INT]    = intensity_i;
  assign cur_s[LANE_INTRIN] = intrinsic_intensity_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign beam_ok    = 32'(beam_index_i) < 32'(BEAMS);
  assign wr_addr    = base_q + ADDR_W'(beam_index_i);
  assign is_full    = beam_ok && (held_q >= (len_c - CNT_W'(1)));

  // Same beam one slot back, wrapping around the ring.
  assign step_addr = (rd_addr_q < BEAMS_A) ? (rd_addr_q + LAST_A) : (rd_addr_q - BEAMS_A);

  // Ring advance on the last beam of a scan.
  always_comb begin
    base_d = base_q;
    held_d = held_q;
    if (accept && scan_end_i) begin
      base_d = (base_q == LAST_A) ? '0 : (base_q + BEAMS_A);
      if (held_q < WIN_C) begin
        held_d = held_q + CNT_W'(1);
      end
    end
  end

  // Sequencer: accept, walk over older slots, drain the last read, deliver.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    rd_vld_d    = 1'b0;
    full_d      = full_q;
    end_d       = end_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    acc_ctrl    = '0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mem_we        = beam_ok;
          acc_ctrl.init = 1'b1;
          full_d        = is_full;
          end_d         = scan_end_i;
          rd_addr_d     = wr_addr;
          cnt_d         = len_c - CNT_W'(1);
          if (is_full && (len_c != CNT_W'(1))) begin
            state_d = S_WALK;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_WALK: begin
        mem_re          = 1'b1;
        rd_addr_d       = step_addr;
        rd_vld_d        = 1'b1;
        acc_ctrl.update = rd_vld_q;
        cnt_d           = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        acc_ctrl.update = rd_vld_q;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      held_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      held_q      <= held_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    rd_addr_q <= rd_addr_d;
    full_q    <= full_d;
    end_q     <= end_d;
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hi_q   <= hi_s;
      out_lo_q   <= lo_s;
      out_full_q <= full_q;
      out_end_q  <= end_q;
    end
  end

  pbwmm_sample_ram #(
    .DEPTH  (TOTAL),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (cur_s),
    .re_i    (mem_re),
    .raddr_i (step_addr),
    .rdata_o (rd_s)
  );

  pbwmm_extreme_acc u_acc (
    .clk_i  (clk_i),
    .ctrl_i (acc_ctrl),
    .cur_i  (cur_s),
    .rd_i   (rd_s),
    .hi_o   (hi_s),
    .lo_o   (lo_s)
  );

  assign out_valid_o     = out_valid_q;
  assign max_distance_o  = out_hi_q[LANE_DIST];
  assign min_distance_o  = out_lo_q[LANE_DIST];
  assign max_intensity_o = out_hi_q[LANE_INT];
  assign min_intensity_o = out_lo_q[LANE_INT];
  assign max_intrinsic_o = out_hi_q[LANE_INTRIN];
  assign min_intrinsic_o = out_lo_q[LANE_INTRIN];
  assign window_full_o   = out_full_q;
  assign scan_done_o     = out_end_q;

endmodule

@@ bench/pbwmm_tb_pkg.sv @@
// Transaction types and the result checker for the per-beam window min/max bench.
// The checker keeps its own scan ring and predicts the extremes of every accepted beam.
// Depends on pbwmm_pkg.
package pbwmm_tb_pkg;
  import pbwmm_pkg::*;

  // Only this many mismatches are printed in full.
  localparam int MAX_REPORTS = 10;

  // One beam as offered on the input channel.
  typedef struct packed {
    logic [BEAM_W-1:0] beam_index;
    logic [VAL_W-1:0]  distance;
    logic [VAL_W-1:0]  intensity;
    logic [VAL_W-1:0]  intrinsic;
    logic              scan_end;
  } beam_item_t;

  // One result transaction.
  typedef struct packed {
    logic [VAL_W-1:0] max_distance;
    logic [VAL_W-1:0] min_distance;
    logic [VAL_W-1:0] max_intensity;
    logic [VAL_W-1:0] min_intensity;
    logic [VAL_W-1:0] max_intrinsic;
    logic [VAL_W-1:0] min_intrinsic;
    logic             window_full;
    logic             scan_done;
  } extremes_t;

  class beam_extremes_checker;
    sample_t          ring_store   [WINDOW_DEF][BEAMS_DEF];
    bit               ring_written [WINDOW_DEF][BEAMS_DEF];
    int unsigned      cur_slot;
    int unsigned      scans_held;
    logic [WL_W-1:0]  window_len;
    extremes_t        due_extremes [$];
    int unsigned      failures;
    int unsigned      results_seen;

    function new();
      cur_slot     = 0;
      scans_held   = 0;
      window_len   = WL_RESET;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void set_window_length(logic [WL_W-1:0] value);
      window_len = value;
    endfunction

    // Window length as the unit applies it: zero counts as one, the ring size caps it.
    function int unsigned span();
      if (window_len == 0) return 1;
      if (window_len > WINDOW_DEF) return WINDOW_DEF;
      return window_len;
    endfunction

    // True when a beam at this position would only read stored entries that were written.
    function bit covered_by_writes(logic [BEAM_W-1:0] beam);
      int unsigned len;
      len = span();
      if (beam >= BEAMS_DEF || scans_held < len - 1) return 1'b1;
      for (int unsigned k = 1; k < len; k++) begin
        if (!ring_written[(cur_slot + WINDOW_DEF - k) % WINDOW_DEF][beam]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Store an accepted beam and queue the extremes it should produce.
    function void note_beam(beam_item_t b);
      logic [VAL_W-1:0] hi [LANES];
      logic [VAL_W-1:0] lo [LANES];
      sample_t          cur;
      sample_t          old;
      extremes_t        e;
      int unsigned      len;
      int unsigned      s;
      cur[LANE_DIST]   = b.distance;
      cur[LANE_INT]    = b.intensity;
      cur[LANE_INTRIN] = b.intrinsic;
      for (int q = 0; q < LANES; q++) begin
        hi[q] = cur[q];
        lo[q] = cur[q];
      end
      len = span();
      e.window_full = 1'b0;
      // Beams outside the scan are neither stored nor compared.
      if (b.beam_index < BEAMS_DEF) begin
        ring_store[cur_slot][b.beam_index]   = cur;
        ring_written[cur_slot][b.beam_index] = 1'b1;
        if (scans_held >= len - 1) begin
          e.window_full = 1'b1;
          for (int unsigned k = 1; k < len; k++) begin
            s   = (cur_slot + WINDOW_DEF - k) % WINDOW_DEF;
            old = ring_store[s][b.beam_index];
            for (int q = 0; q < LANES; q++) begin
              if (old[q] > hi[q]) hi[q] = old[q];
              if (old[q] < lo[q]) lo[q] = old[q];
            end
          end
        end
      end
      e.max_distance  = hi[LANE_DIST];
      e.min_distance  = lo[LANE_DIST];
      e.max_intensity = hi[LANE_INT];
      e.min_intensity = lo[LANE_INT];
      e.max_intrinsic = hi[LANE_INTRIN];
      e.min_intrinsic = lo[LANE_INTRIN];
      e.scan_done     = b.scan_end;
      // The last beam of a scan moves the ring on, even when it was not stored.
      if (b.scan_end) begin
        cur_slot = (cur_slot + 1) % WINDOW_DEF;
        if (scans_held < WINDOW_DEF) scans_held++;
      end
      due_extremes = {due_extremes, e};
    endfunction

    function void flag(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
      end
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_extremes(extremes_t got);
      extremes_t want;
      results_seen++;
      if (due_extremes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing expected", results_seen);
        end
        return;
      end
      want = due_extremes.pop_front();
      if (got.max_distance !== want.max_distance)
        flag("max_distance", want.max_distance, got.max_distance);
      if (got.min_distance !== want.min_distance)
        flag("min_distance", want.min_distance, got.min_distance);
      if (got.max_intensity !== want.max_intensity)
        flag("max_intensity", want.max_intensity, got.max_intensity);
      if (got.min_intensity !== want.min_intensity)
        flag("min_intensity", want.min_intensity, got.min_intensity);
      if (got.max_intrinsic !== want.max_intrinsic)
        flag("max_intrinsic", want.max_intrinsic, got.max_intrinsic);
      if (got.min_intrinsic !== want.min_intrinsic)
        flag("min_intrinsic", want.min_intrinsic, got.min_intrinsic);
      if (got.window_full !== want.window_full)
        flag("window_full", want.window_full, got.window_full);
      if (got.scan_done !== want.scan_done)
        flag("scan_done", want.scan_done, got.scan_done);
    endfunction
  endclass

endpackage

@@ bench/per_beam_window_min_max_unit_tb.sv @@
// Testbench for per_beam_window_min_max_unit: directed beams, then random scans under
// several window lengths, with bursty input, output stalls and one long output hold-off.
// Depends on pbwmm_pkg, pbwmm_tb_pkg and the unit's RTL.
module per_beam_window_min_max_unit_tb;
  import pbwmm_pkg::*;
  import pbwmm_tb_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE       = 4;
  localparam int TAIL_CYCLES  = WINDOW_DEF + 8;
  localparam logic [BEAM_W-1:0] BEAM_FIRST    = '0;
  localparam logic [BEAM_W-1:0] BEAM_LAST     = BEAM_W'(BEAMS_DEF - 1);
  localparam logic [BEAM_W-1:0] BEAM_CODE_MAX = '1;

  // Output-side ready patterns.
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SLOW,
    RX_PERIODIC
  } rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WL_W-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [BEAM_W-1:0] beam_index_i;
  logic [VAL_W-1:0]  distance_i;
  logic [VAL_W-1:0]  intensity_i;
  logic [VAL_W-1:0]  intrinsic_intensity_i;
  logic              scan_end_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [VAL_W-1:0]  max_distance_o;
  logic [VAL_W-1:0]  min_distance_o;
  logic [VAL_W-1:0]  max_intensity_o;
  logic [VAL_W-1:0]  min_intensity_o;
  logic [VAL_W-1:0]  max_intrinsic_o;
  logic [VAL_W-1:0]  min_intrinsic_o;
  logic              window_full_o;
  logic              scan_done_o;

  beam_extremes_checker sb;
  extremes_t            seen_result;
  int                   burst_left = 0;
  int                   quiet_cycles = 0;
  bit                   hold_off_req = 1'b0;

  per_beam_window_min_max_unit u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .beam_index_i          (beam_index_i),
    .distance_i            (distance_i),
    .intensity_i           (intensity_i),
    .intrinsic_intensity_i (intrinsic_intensity_i),
    .scan_end_i            (scan_end_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .max_distance_o        (max_distance_o),
    .min_distance_o        (min_distance_o),
    .max_intensity_o       (max_intensity_o),
    .min_intensity_o       (min_intensity_o),
    .max_intrinsic_o       (max_intrinsic_o),
    .min_intrinsic_o       (min_intrinsic_o),
    .window_full_o         (window_full_o),
    .scan_done_o           (scan_done_o)
  );

  always #6 clk_i = ~clk_i;

  // Samples lean toward the range ends so that ties and extremes show up often.
  function automatic logic [VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return VAL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Offer one beam and hold it until the unit takes it; bursts are usually separated by gaps.
  task automatic send_beam(input beam_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i            <= 1'b1;
    beam_index_i          <= item.beam_index;
    distance_i            <= item.distance;
    intensity_i           <= item.intensity;
    intrinsic_intensity_i <= item.intrinsic;
    scan_end_i            <= item.scan_end;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beam(item);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [BEAM_W-1:0] beam, input logic [VAL_W-1:0] range_mm,
                             input logic [VAL_W-1:0] inten, input logic [VAL_W-1:0] intrin,
                             input logic last);
    beam_item_t item;
    item.beam_index = beam;
    item.distance   = range_mm;
    item.intensity  = inten;
    item.intrinsic  = intrin;
    item.scan_end   = last;
    send_beam(item);
  endtask

  // One scan: both end beams plus a few random positions, some of them out of range.
  task automatic send_scan();
    logic [BEAM_W-1:0] beams [$];
    beam_item_t        item;
    int                n_extra;
    n_extra = $urandom_range(0, 3);
    beams = {BEAM_FIRST};
    beams.insert($urandom_range(0, beams.size()), BEAM_LAST);
    repeat (n_extra) begin
      if ($urandom_range(0, 9) < 7) begin
        beams.insert($urandom_range(0, beams.size()), BEAM_W'($urandom_range(0, BEAMS_DEF - 1)));
      end else begin
        beams.insert($urandom_range(0, beams.size()),
                     BEAM_W'($urandom_range(BEAMS_DEF, BEAM_CODE_MAX)));
      end
    end
    foreach (beams[i]) begin
      item.beam_index = beams[i];
      // A position missing from an older scan in the window is swapped for one off the scan.
      if (!sb.covered_by_writes(item.beam_index)) begin
        item.beam_index = BEAM_W'($urandom_range(BEAMS_DEF, BEAM_CODE_MAX));
      end
      item.distance  = pick_sample();
      item.intensity = pick_sample();
      item.intrinsic = pick_sample();
      item.scan_end  = (i == beams.size() - 1);
      send_beam(item);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due_extremes.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_window_length(input logic [WL_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window_length(value);
    @(negedge clk_i);
  endtask

  // Main sequence.
  initial begin
    sb                    = new();
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    in_valid_i            = 1'b0;
    beam_index_i          = '0;
    distance_i            = '0;
    intensity_i           = '0;
    intrinsic_intensity_i = '0;
    scan_end_i            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Two-scan window with directed beams: field extremes, repeated and off-scan positions.
    write_window_length(9'd2);
    send_fields(BEAM_FIRST,    16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_fields(BEAM_LAST,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_fields(BEAM_CODE_MAX, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    send_fields(10'd341,       16'hAAAA, 16'h5555, 16'h00FF, 1'b0);
    send_fields(10'd721,       16'h8000, 16'h0001, 16'hFFFE, 1'b1);
    send_fields(BEAM_FIRST,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_fields(BEAM_LAST,     16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_fields(10'd341,       16'h5555, 16'hAAAA, 16'hFF00, 1'b0);
    send_fields(BEAM_FIRST,    16'h0001, 16'h8000, 16'h7FFF, 1'b0);
    send_fields(10'd1000,      16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_fields(BEAM_LAST,     16'hFFFF, 16'h0000, 16'h8000, 1'b0);
    send_fields(BEAM_FIRST,    16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_fields(10'd341,       16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send_fields(BEAM_LAST,     16'h0001, 16'h0001, 16'h0001, 1'b0);
    send_fields(BEAM_FIRST,    16'h0002, 16'h0002, 16'h0002, 1'b0);
    send_fields(BEAM_LAST,     16'h0003, 16'h0003, 16'h0003, 1'b1);

    // Random scans; partway through, the output side holds off so the unit backs up.
    for (int n = 0; n < 60; n++) begin
      if (n == 10) hold_off_req = 1'b1;
      send_scan();
    end
    settle();

    // A zero length behaves as a window of one scan.
    write_window_length(9'd0);
    repeat (30) send_scan();
    settle();

    // Full ring: fill it until the window is complete, then walk it.
    write_window_length(9'd400);
    while (sb.scans_held < WINDOW_DEF - 1) send_scan();
    repeat (20) send_scan();
    settle();

    // A length beyond the ring is capped.
    write_window_length(9'h1FF);
    repeat (8) send_scan();
    settle();

    // A few mid-size windows over a saturated ring.
    repeat (3) begin
      write_window_length(WL_W'($urandom_range(3, 60)));
      repeat (20) send_scan();
      settle();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.failures == 0 && sb.due_extremes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output ready follows changing patterns, with one long hold-off on request.
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       tick;
    mode        = RX_STEADY;
    mode_left   = 0;
    tick        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(RX_STEADY, RX_PERIODIC));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_STEADY:   out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
        RX_SLOW:     out_ready_i <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready_i <= ((tick % 5) < 2);
        default:     out_ready_i <= 1'b1;
      endcase
    end
  end

  // Every result transaction goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.max_distance  = max_distance_o;
      seen_result.min_distance  = min_distance_o;
      seen_result.max_intensity = max_intensity_o;
      seen_result.min_intensity = min_intensity_o;
      seen_result.max_intrinsic = max_intrinsic_o;
      seen_result.min_intrinsic = min_intrinsic_o;
      seen_result.window_full   = window_full_o;
      seen_result.scan_done     = scan_done_o;
      sb.check_extremes(seen_result);
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
